// ===== sv/efsd_pkg.sv =====
// Shared types, widths and helpers for the earliest-free-server dispatcher.
// No dependencies; used by efsd_ctrl, efsd_dp and the top-level dispatcher.
`timescale 1ns / 1ps

package efsd_pkg;

  localparam int SRV_W           = 4;
  localparam int TIME_W          = 16;
  localparam int TOT_W           = 32;
  localparam int CFG_W           = 5;
  localparam int DEF_MAX_SERVERS = 16;
  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);

  typedef struct packed {
    logic              new_batch;
    logic [TIME_W-1:0] service_time;
    logic [TIME_W-1:0] job_cost;
  } in_item_t;

  typedef struct packed {
    logic [SRV_W-1:0] chosen_server;
    logic [TOT_W-1:0] server_finish;
    logic [TOT_W-1:0] server_cost_total;
    logic [TOT_W-1:0] makespan;
  } out_item_t;

  typedef struct packed {
    logic [TOT_W-1:0] finish;
    logic [TOT_W-1:0] cost;
  } srv_entry_t;

  typedef struct packed {
    logic capture;
    logic seed;
    logic scan_rd;
    logic fetch_rd;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic seed_avail;
    logic scan_last;
    logic out_free;
  } dp_sts_t;

  function automatic logic [TOT_W-1:0] sat_add(input logic [TOT_W-1:0] a,
                                                input logic [TIME_W-1:0] b);
    logic [TOT_W:0] s;
    s = {1'b0, a} + {{(TOT_W + 1 - TIME_W){1'b0}}, b};
    return s[TOT_W] ? {TOT_W{1'b1}} : s[TOT_W-1:0];
  endfunction

endpackage

// ===== sv/efsd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module efsd_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== sv/efsd_ctrl.sv =====
// Controller for the dispatcher: sequences capture, seeding, minimum scan,
// fetch and commit. Depends on efsd_pkg for the command and status types.
`timescale 1ns / 1ps

module efsd_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  efsd_pkg::dp_sts_t   sts,
  output efsd_pkg::ctrl_cmd_t cmd
);

  import efsd_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_SCAN,
    ST_DRAIN,
    ST_FETCH,
    ST_UPDATE
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (sts.seed_avail) begin
          cmd.seed  = 1'b1;
          state_nxt = ST_FETCH;
        end else begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (sts.scan_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_FETCH;
      end
      ST_FETCH: begin
        cmd.fetch_rd = 1'b1;
        state_nxt    = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== sv/efsd_dp.sv =====
// Datapath for the dispatcher: server-state RAM with valid bits, scan and
// minimum registers, saturating update and the output register.
// Depends on efsd_pkg and efsd_ram.
`timescale 1ns / 1ps

module efsd_dp #(
  parameter int MAX_SERVERS = efsd_pkg::DEF_MAX_SERVERS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [efsd_pkg::CFG_W-1:0]        cfg_wr_data,
  input  efsd_pkg::in_item_t                in_data,
  input  efsd_pkg::ctrl_cmd_t               cmd,
  output efsd_pkg::dp_sts_t                 sts,
  output logic                              out_valid,
  input  logic                              out_stall,
  output efsd_pkg::out_item_t               out_data
);

  import efsd_pkg::*;

  localparam int IDX_W = $clog2(MAX_SERVERS);
  localparam int CNT_W = $clog2(MAX_SERVERS + 1);
  localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int ENT_W = 2 * TOT_W;

  logic [CFG_W-1:0]       servers_in_use_r;
  logic [CNT_W-1:0]       n_act;
  logic [CMP_W-1:0]       cfg_ext;
  logic [CMP_W-1:0]       n_clamp;

  logic [TIME_W-1:0]      time_r;
  logic [TIME_W-1:0]      cost_r;
  logic [CNT_W-1:0]       seeded_r;
  logic [TOT_W-1:0]       longest_r;
  logic [MAX_SERVERS-1:0] valid_r;

  logic [IDX_W-1:0]       scan_idx_r;
  logic                   cmp_pending_r;
  logic [IDX_W-1:0]       cmp_idx_r;
  logic                   rd_ok_r;
  logic [TOT_W-1:0]       min_r;
  logic [IDX_W-1:0]       pick_r;

  logic                   rd_en;
  logic [IDX_W-1:0]       rd_addr;
  logic [ENT_W-1:0]       rd_raw;
  srv_entry_t             rd_ent;
  srv_entry_t             wr_ent;
  logic [TOT_W-1:0]       new_finish;
  logic [TOT_W-1:0]       new_cost;
  logic [TOT_W-1:0]       new_longest;

  logic                   out_valid_r;
  out_item_t              out_data_r;

  assign cfg_ext = CMP_W'(servers_in_use_r);
  always_comb begin
    if (cfg_ext == '0) begin
      n_clamp = CMP_W'(1);
    end else if (cfg_ext > CMP_W'(MAX_SERVERS)) begin
      n_clamp = CMP_W'(MAX_SERVERS);
    end else begin
      n_clamp = cfg_ext;
    end
  end
  assign n_act = CNT_W'(n_clamp);

  assign rd_en   = cmd.scan_rd | cmd.fetch_rd;
  assign rd_addr = cmd.fetch_rd ? pick_r : scan_idx_r;

  efsd_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_SERVERS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (cmd.commit),
    .wr_addr (pick_r),
    .wr_data (wr_ent),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_raw)
  );

  assign rd_ent      = rd_ok_r ? srv_entry_t'(rd_raw) : '0;
  assign new_finish  = sat_add(rd_ent.finish, time_r);
  assign new_cost    = sat_add(rd_ent.cost, cost_r);
  assign new_longest = (new_finish > longest_r) ? new_finish : longest_r;
  assign wr_ent      = '{finish: new_finish, cost: new_cost};

  assign sts.seed_avail = (seeded_r < n_act);
  assign sts.scan_last  = (CNT_W'(scan_idx_r) == (n_act - CNT_W'(1)));
  assign sts.out_free   = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      servers_in_use_r <= CFG_RESET;
      seeded_r         <= '0;
      longest_r        <= '0;
      valid_r          <= '0;
      cmp_pending_r    <= 1'b0;
      out_valid_r      <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        servers_in_use_r <= cfg_wr_data;
      end
      if (cmd.capture && in_data.new_batch) begin
        seeded_r  <= '0;
        longest_r <= '0;
        valid_r   <= '0;
      end
      if (cmd.seed) begin
        seeded_r <= seeded_r + CNT_W'(1);
      end
      cmp_pending_r <= cmd.scan_rd;
      if (cmd.commit) begin
        valid_r[pick_r] <= 1'b1;
        longest_r       <= new_longest;
        out_valid_r     <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      time_r     <= in_data.service_time;
      cost_r     <= in_data.job_cost;
      scan_idx_r <= '0;
    end
    if (cmd.scan_rd) begin
      scan_idx_r <= scan_idx_r + IDX_W'(1);
      cmp_idx_r  <= scan_idx_r;
    end
    if (rd_en) begin
      rd_ok_r <= valid_r[rd_addr];
    end
    if (cmd.seed) begin
      pick_r <= seeded_r[IDX_W-1:0];
    end
    if (cmp_pending_r) begin
      if ((cmp_idx_r == '0) || (rd_ent.finish < min_r)) begin
        min_r  <= rd_ent.finish;
        pick_r <= cmp_idx_r;
      end
    end
    if (cmd.commit) begin
      out_data_r.chosen_server     <= SRV_W'(pick_r);
      out_data_r.server_finish     <= new_finish;
      out_data_r.server_cost_total <= new_cost;
      out_data_r.makespan          <= new_longest;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== sv/earliest_free_server_dispatch.sv =====
// Earliest-free-server dispatcher: places each job on a server and reports the
// server's new finish time, cost total and the batch makespan, one result per
// job. A job that seeds a fresh server passes the decide, fetch and update
// states before the next possible transfer; a job that searches also passes
// the scan and drain states, where the minimum search over the active servers
// reads one entry per cycle through the single read port of the server-state
// RAM. A finished result sits in an output register, so a new job is taken
// while it waits. Depends on efsd_pkg, efsd_ctrl, efsd_dp and efsd_ram.
`timescale 1ns / 1ps

module earliest_free_server_dispatch #(
  parameter int MAX_SERVERS = efsd_pkg::DEF_MAX_SERVERS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [efsd_pkg::CFG_W-1:0] cfg_wr_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  efsd_pkg::in_item_t         in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output efsd_pkg::out_item_t        out_data
);

  import efsd_pkg::*;

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  efsd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  efsd_dp #(
    .MAX_SERVERS (MAX_SERVERS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_data     (in_data),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken again right after a transfer");

  a_commit_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid)
    else $error("commit did not present a result");

  a_commit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_valid || !out_stall))
    else $error("commit overwrote a pending result");

  a_makespan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.makespan >= out_data.server_finish))
    else $error("makespan below server finish time");

endmodule
